// ===== rtl/rhcd_pkg.sv =====
package rhcd_pkg;

  // Message numbers handled by the decoder
  localparam logic [5:0] MsgPhase = 6'd20;
  localparam logic [5:0] MsgRange = 6'd21;

  // Shortest packet accepted: a header word and two records
  localparam logic [4:0] MinWords = 5'd5;

  // Modified z-count unit (0.6 s) in microseconds
  localparam logic [19:0] UsPerZCount = 20'd600000;

  // Satellite numbering
  localparam logic [7:0] GloPrnBase = 8'd200;
  localparam logic [7:0] GpsPrnZero = 8'd32;

  // Lock store entry: L2 indicator above L1 indicator
  localparam int unsigned LockW  = 5;
  localparam int unsigned EntryW = 2 * LockW;
  localparam int unsigned RawSlotW = 6;

  // Item handed from the word stage to the record stage
  typedef struct packed {
    logic                is_hdr;
    logic [32:0]         epoch_us;
    logic [7:0]          sat_number;
    logic                is_range;
    logic                is_l2;
    logic [23:0]         corr;
    logic [7:0]          rate;
    logic [1:0]          scale;
    logic [7:0]          iod;
    logic [LockW-1:0]    lock;
    logic                p_code;
    logic [RawSlotW-1:0] slot;
    logic                last;
    logic                done_val;
  } stage_t;

endpackage

// ===== rtl/rhcd_lock_mem.sv =====
module rhcd_lock_mem import rhcd_pkg::*; #(
  parameter int unsigned SAT_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(SAT_SLOTS)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(SAT_SLOTS)-1:0] wr_addr_i,
  input  logic [EntryW-1:0]            wr_data_i,
  output logic [EntryW-1:0]            rd_data_o
);

  logic [EntryW-1:0]    mem_q [SAT_SLOTS];
  logic [SAT_SLOTS-1:0] vld_q;
  logic [EntryW-1:0]    rd_q;
  logic                 rd_vld_q;
  logic                 fwd_q;
  logic [EntryW-1:0]    fwd_data_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Entry valid bits, and capture a same-cycle write to the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // Unwritten entries read as zero; a colliding write wins
  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

// ===== rtl/rhcd_word_stage.sv =====
module rhcd_word_stage import rhcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [5:0]  message_type_i,
  input  logic        packet_ok_i,
  input  logic [12:0] modified_z_count_i,
  input  logic [4:0]  word_total_i,
  input  logic [4:0]  word_number_i,
  input  logic [23:0] data_word_i,
  output logic        load_o,
  output stage_t      stage_o
);

  logic        pkt_acc_q;
  logic        l2_q;
  logic        multi_q;
  logic [23:0] first_q;

  logic        good;
  logic        in_pkt;
  logic        is_hdr;
  logic        is_odd;
  logic        is_rec;
  logic        is21;
  logic        glo;
  logic [4:0]  prn5;
  logic [7:0]  prn8;

  // Classify the word
  assign good   = packet_ok_i
               && ((message_type_i == MsgPhase) || (message_type_i == MsgRange))
               && (word_total_i >= MinWords) && word_total_i[0];
  assign in_pkt = word_number_i < word_total_i;
  assign is_hdr = good && in_pkt && (word_number_i == '0);
  assign is_odd = good && in_pkt && (word_number_i != '0) && pkt_acc_q && word_number_i[0];
  assign is_rec = good && in_pkt && (word_number_i != '0) && pkt_acc_q && !word_number_i[0];
  assign load_o = is_hdr || is_rec;

  assign is21 = (message_type_i == MsgRange);
  assign glo  = first_q[21];
  assign prn5 = first_q[20:16];
  assign prn8 = {3'b000, prn5};

  // Build the item for the record stage
  always_comb begin
    stage_o          = '0;
    stage_o.is_hdr   = is_hdr;
    stage_o.epoch_us = 33'(modified_z_count_i) * 33'(UsPerZCount) + 33'(data_word_i[19:0]);
    if (glo) begin
      stage_o.sat_number = prn8 + GloPrnBase;
    end else if (prn5 == '0) begin
      stage_o.sat_number = GpsPrnZero;
    end else begin
      stage_o.sat_number = prn8;
    end
    stage_o.is_range = is21;
    stage_o.is_l2    = l2_q;
    stage_o.iod      = first_q[7:0];
    stage_o.slot     = {glo, prn5};
    stage_o.last     = ({1'b0, word_number_i} + 6'd1) == {1'b0, word_total_i};
    stage_o.done_val = !(multi_q && first_q[23]);
    if (is21) begin
      stage_o.corr   = {{8{data_word_i[23]}}, data_word_i[23:8]};
      stage_o.rate   = data_word_i[7:0];
      stage_o.scale  = {first_q[15], first_q[11]};
      stage_o.p_code = first_q[22];
    end else begin
      stage_o.corr   = data_word_i;
      stage_o.lock   = first_q[12:8];
    end
  end

  // Packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_acc_q <= 1'b0;
      l2_q      <= 1'b0;
      multi_q   <= 1'b1;
    end else if (accept_i) begin
      if (!good && (word_number_i == '0)) begin
        pkt_acc_q <= 1'b0;
      end
      if (is_hdr) begin
        l2_q      <= data_word_i[23];
        pkt_acc_q <= !data_word_i[22];
        multi_q   <= 1'b1;
      end
      if (is_rec) begin
        multi_q <= multi_q && first_q[23];
      end
    end
  end

  // Hold the first half of a record
  always_ff @(posedge clk_i) begin
    if (accept_i && is_odd) begin
      first_q <= data_word_i;
    end
  end

endmodule

// ===== rtl/rtcm2_hires_correction_decoder_core.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | message_type_i .. data_word_i
// out     | output    | out_valid_o/out_ready_i | sat_number_o .. epoch_complete_o
//
// One data word per cycle while the input is not stalled. After its second
// half is taken, a record passes the word stage (decode, lock store read) and
// the record stage (compare, write back, fill the output register).
// Reset presets all flags, clears the lock store valid bits at once; no sweep.
// A waiting result stalls the input only when the record stage holds a record.
module rtcm2_hires_correction_decoder_core import rhcd_pkg::*; #(
  parameter int unsigned SAT_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [5:0]         message_type_i,
  input  logic               packet_ok_i,
  input  logic [12:0]        modified_z_count_i,
  input  logic [4:0]         word_total_i,
  input  logic [4:0]         word_number_i,
  input  logic [23:0]        data_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         sat_number_o,
  output logic               is_range_o,
  output logic               is_second_freq_o,
  output logic signed [23:0] corr_raw_o,
  output logic signed [7:0]  rate_raw_o,
  output logic [1:0]         scale_codes_o,
  output logic [7:0]         issue_of_data_o,
  output logic [4:0]         lock_count_o,
  output logic               slip_o,
  output logic               p_code_flag_o,
  output logic [32:0]        epoch_us_o,
  output logic               epoch_complete_o
);

  localparam int unsigned SlotW = $clog2(SAT_SLOTS);

  logic              accept;
  logic              load;
  stage_t            stage;
  logic              s1_valid_q;
  stage_t            s1_q;
  logic              s1_adv;
  logic [32:0]       epoch_time_q;
  logic              epoch_done_q;
  logic              out_valid_q;
  logic [EntryW-1:0] entry_rd;
  logic [EntryW-1:0] entry_wr;
  logic [LockW-1:0]  old_lock;
  logic              slip;
  logic              lock_wr;
  logic              done_out;

  assign accept     = in_valid_i && in_ready_o;
  assign s1_adv     = s1_valid_q && (s1_q.is_hdr || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  rhcd_word_stage u_word (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .message_type_i,
    .packet_ok_i,
    .modified_z_count_i,
    .word_total_i,
    .word_number_i,
    .data_word_i,
    .load_o   (load),
    .stage_o  (stage)
  );

  rhcd_lock_mem #(.SAT_SLOTS(SAT_SLOTS)) u_lock (
    .clk_i,
    .rst_ni,
    .rd_en_i   (accept && load),
    .rd_addr_i (SlotW'(stage.slot)),
    .wr_en_i   (lock_wr),
    .wr_addr_i (SlotW'(s1_q.slot)),
    .wr_data_i (entry_wr),
    .rd_data_o (entry_rd)
  );

  // Compare the lock indicator and merge it into the entry
  assign old_lock = s1_q.is_l2 ? entry_rd[EntryW-1:LockW] : entry_rd[LockW-1:0];
  assign slip     = !s1_q.is_range && (old_lock != s1_q.lock);
  assign entry_wr = s1_q.is_l2 ? {s1_q.lock, entry_rd[LockW-1:0]}
                               : {entry_rd[EntryW-1:LockW], s1_q.lock};
  assign lock_wr  = s1_adv && !s1_q.is_hdr && !s1_q.is_range;
  assign done_out = s1_q.last ? s1_q.done_val : epoch_done_q;

  // Record stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && load) begin
      s1_q <= stage;
    end
  end

  // Epoch tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_time_q <= '0;
      epoch_done_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_q.is_hdr) begin
        if ((s1_q.epoch_us != epoch_time_q) || epoch_done_q) begin
          epoch_time_q <= s1_q.epoch_us;
          epoch_done_q <= 1'b0;
        end
      end else if (s1_q.last) begin
        epoch_done_q <= s1_q.done_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && !s1_q.is_hdr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_q.is_hdr) begin
      sat_number_o     <= s1_q.sat_number;
      is_range_o       <= s1_q.is_range;
      is_second_freq_o <= s1_q.is_l2;
      corr_raw_o       <= s1_q.corr;
      rate_raw_o       <= s1_q.rate;
      scale_codes_o    <= s1_q.scale;
      issue_of_data_o  <= s1_q.iod;
      lock_count_o     <= s1_q.lock;
      slip_o           <= slip;
      p_code_flag_o    <= s1_q.p_code;
      epoch_us_o       <= epoch_time_q;
      epoch_complete_o <= done_out;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/rtcm2_hires_correction_decoder_core_tb.sv =====
module rtcm2_hires_correction_decoder_core_tb;
  import rhcd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomWords = 1950;
  localparam int unsigned CalmTail = 150;

  // One data word as the deframer hands it over
  typedef struct packed {
    logic [5:0]  message_type;
    logic        packet_ok;
    logic [12:0] z_count;
    logic [4:0]  word_total;
    logic [4:0]  word_number;
    logic [23:0] data_word;
    logic        wait_for_drain;
  } data_item_t;

  // One decoded satellite record
  typedef struct packed {
    logic [7:0]  sat;
    logic        is_range;
    logic        l2;
    logic [23:0] corr;
    logic [7:0]  rate;
    logic [1:0]  scale;
    logic [7:0]  iod;
    logic [4:0]  lock;
    logic        slip;
    logic        p_code;
    logic [32:0] epoch;
    logic        done;
  } sat_record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [5:0] message_type_i = '0;
  logic packet_ok_i = 1'b0;
  logic [12:0] modified_z_count_i = '0;
  logic [4:0] word_total_i = '0;
  logic [4:0] word_number_i = '0;
  logic [23:0] data_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] sat_number_o;
  logic is_range_o;
  logic is_second_freq_o;
  logic signed [23:0] corr_raw_o;
  logic signed [7:0] rate_raw_o;
  logic [1:0] scale_codes_o;
  logic [7:0] issue_of_data_o;
  logic [4:0] lock_count_o;
  logic slip_o;
  logic p_code_flag_o;
  logic [32:0] epoch_us_o;
  logic epoch_complete_o;

  rtcm2_hires_correction_decoder_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .message_type_i,
    .packet_ok_i,
    .modified_z_count_i,
    .word_total_i,
    .word_number_i,
    .data_word_i,
    .out_valid_o,
    .out_ready_i,
    .sat_number_o,
    .is_range_o,
    .is_second_freq_o,
    .corr_raw_o,
    .rate_raw_o,
    .scale_codes_o,
    .issue_of_data_o,
    .lock_count_o,
    .slip_o,
    .p_code_flag_o,
    .epoch_us_o,
    .epoch_complete_o
  );

  data_item_t word_queue[$];
  sat_record_t record_queue[$];
  data_item_t cur_word;
  logic word_pending = 1'b0;
  logic drain_next = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned in_odds = 0;
  int unsigned out_odds = 0;

  // Decoder state mirrored on the bench side
  logic [32:0] epoch_now = '0;
  logic epoch_closed = 1'b0;
  logic pkt_open = 1'b0;
  logic pkt_l2 = 1'b0;
  logic [23:0] held_first = '0;
  logic multi_all = 1'b1;
  logic [9:0] lock_mem [64] = '{default: '0};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the decoder state by one accepted word, queue the record it yields
  task automatic decode_word(input data_item_t w);
    logic good;
    logic is21;
    logic [32:0] epoch;
    logic [23:0] a;
    logic [4:0] prn;
    logic [4:0] ll;
    logic [4:0] old_ll;
    logic [5:0] slot;
    sat_record_t r;
    good = w.packet_ok && (w.message_type == MsgPhase || w.message_type == MsgRange) &&
           w.word_total >= MinWords && w.word_total[0];
    if (!good) begin
      if (w.word_number == '0) pkt_open = 1'b0;
    end else if (w.word_number < w.word_total) begin
      if (w.word_number == '0) begin
        epoch = 33'(w.z_count) * 33'(UsPerZCount) + 33'(w.data_word[19:0]);
        if (epoch != epoch_now || epoch_closed) begin
          epoch_now = epoch;
          epoch_closed = 1'b0;
        end
        pkt_l2 = w.data_word[23];
        pkt_open = !w.data_word[22];
        multi_all = 1'b1;
      end else if (pkt_open && w.word_number[0]) begin
        held_first = w.data_word;
      end else if (pkt_open) begin
        a = held_first;
        prn = a[20:16];
        slot = {a[21], prn};
        is21 = (w.message_type == MsgRange);
        multi_all = multi_all && a[23];
        r = '0;
        r.sat = a[21] ? 8'(prn) + GloPrnBase : (prn == '0 ? GpsPrnZero : 8'(prn));
        r.is_range = is21;
        r.l2 = pkt_l2;
        r.iod = a[7:0];
        if (!is21) begin
          // compare and update the lock indicator of this frequency
          ll = a[12:8];
          old_ll = pkt_l2 ? lock_mem[slot][9:5] : lock_mem[slot][4:0];
          r.slip = (old_ll != ll);
          if (pkt_l2) lock_mem[slot][9:5] = ll;
          else lock_mem[slot][4:0] = ll;
          r.lock = ll;
          r.corr = w.data_word;
        end else begin
          r.corr = {{8{w.data_word[23]}}, w.data_word[23:8]};
          r.rate = w.data_word[7:0];
          r.scale = {a[15], a[11]};
          r.p_code = a[22];
        end
        if ({1'b0, w.word_number} + 6'd1 == {1'b0, w.word_total}) epoch_closed = !multi_all;
        r.epoch = epoch_now;
        r.done = epoch_closed;
        record_queue.push_back(r);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors < 40) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    end
  endfunction

  task automatic push_word(input logic [5:0] mt, input logic ok, input logic [12:0] zc,
                           input logic [4:0] total, input logic [4:0] wn,
                           input logic [23:0] data);
    data_item_t it;
    it = '{mt, ok, zc, total, wn, data, drain_next};
    drain_next = 1'b0;
    word_queue.push_back(it);
  endtask

  // Drive input words and the output ready at the falling edge
  always @(negedge clk_i) begin
    logic calm;
    if (rst_ni) begin
      calm = (word_queue.size() < CalmTail);
      if (calm) begin
        in_gap = 0;
      end
      if (cycle_count % 256 == 0) begin
        in_odds = $urandom_range(0, 3);
        out_odds = $urandom_range(0, 3);
      end
      if (!word_pending) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (word_queue.size() > 0 &&
                     !(word_queue[0].wait_for_drain && record_queue.size() > 0)) begin
          cur_word = word_queue.pop_front();
          message_type_i <= cur_word.message_type;
          packet_ok_i <= cur_word.packet_ok;
          modified_z_count_i <= cur_word.z_count;
          word_total_i <= cur_word.word_total;
          word_number_i <= cur_word.word_number;
          data_word_i <= cur_word.data_word;
          in_valid_i <= 1'b1;
          word_pending = 1'b1;
          if (!calm && in_odds != 0 && $urandom_range(1, 8) <= in_odds) begin
            in_gap = $urandom_range(1, 14);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0 && !calm) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_gap = 0;
        out_ready_i <= 1'b1;
        if (!calm && out_odds != 0 && $urandom_range(1, 8) <= out_odds) begin
          out_gap = $urandom_range(1, 14);
        end
      end
    end
  end

  // Check records and predict on accepted words at the rising edge
  always @(posedge clk_i) begin
    sat_record_t want;
    cycle_count++;
    if (out_valid_o && out_ready_i) begin
      if (record_queue.size() == 0) begin
        errors++;
        $display("%0t: record with none expected, expected none actual sat %0d", $time,
                 sat_number_o);
      end else begin
        want = record_queue.pop_front();
        check_field("sat_number", want.sat, sat_number_o);
        check_field("is_range", want.is_range, is_range_o);
        check_field("is_second_freq", want.l2, is_second_freq_o);
        check_field("corr_raw", want.corr, {corr_raw_o});
        check_field("rate_raw", want.rate, {rate_raw_o});
        check_field("scale_codes", want.scale, scale_codes_o);
        check_field("issue_of_data", want.iod, issue_of_data_o);
        check_field("lock_count", want.lock, lock_count_o);
        check_field("slip", want.slip, slip_o);
        check_field("p_code_flag", want.p_code, p_code_flag_o);
        check_field("epoch_us", want.epoch, epoch_us_o);
        check_field("epoch_complete", want.done, epoch_complete_o);
      end
    end
    if (in_valid_i && in_ready_o) begin
      decode_word(cur_word);
      word_pending = 1'b0;
    end
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int wn;
    logic [5:0] mt;
    logic [4:0] total;
    logic [4:0] cut;
    logic [12:0] zc;
    logic [19:0] us;
    logic [23:0] a;
    logic [23:0] hdr;
    zc = '0;
    us = '0;

    // Phase packet at the largest epoch, GPS PRN zero, extreme corrections
    push_word(MsgPhase, 1'b1, 13'h1FFF, 5'd5, 5'd0, 24'h3FFFFF);
    push_word(MsgPhase, 1'b1, 13'h1FFF, 5'd5, 5'd1, 24'h40FFFF);
    push_word(MsgPhase, 1'b1, 13'h1FFF, 5'd5, 5'd2, 24'h7FFFFF);
    push_word(MsgPhase, 1'b1, 13'h1FFF, 5'd5, 5'd3, 24'hBF0000);
    push_word(MsgPhase, 1'b1, 13'h1FFF, 5'd5, 5'd4, 24'h800000);
    // Same epoch after completion reopens it; range packet on L2
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd0, 24'hBFFFFF);
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd1, 24'hC5885A);
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd2, 24'h800080);
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd3, 24'hA00000);
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd4, 24'h7FFF7F);
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd5, 24'hFFFFFF);
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd6, 24'h123456);
    // word past the end of the packet
    push_word(MsgRange, 1'b1, 13'h1FFF, 5'd7, 5'd31, 24'hFFFFFF);
    // Bad header closes the packet, a following record word is dropped
    push_word(MsgPhase, 1'b0, 13'd5, 5'd5, 5'd0, 24'h000010);
    push_word(MsgPhase, 1'b1, 13'd5, 5'd5, 5'd2, 24'h000001);
    // Header without usable frequency: epoch moves, records dropped
    push_word(MsgPhase, 1'b1, 13'd0, 5'd5, 5'd0, 24'h400000);
    push_word(MsgPhase, 1'b1, 13'd0, 5'd5, 5'd1, 24'h000000);
    push_word(MsgPhase, 1'b1, 13'd0, 5'd5, 5'd2, 24'hABCDEF);
    // Rejected headers: other message, even count, short packet
    push_word(6'd63, 1'b1, 13'd7, 5'd5, 5'd0, 24'h000020);
    push_word(MsgPhase, 1'b1, 13'd7, 5'd4, 5'd0, 24'h000020);
    push_word(MsgRange, 1'b1, 13'd7, 5'd3, 5'd0, 24'h000020);
    // Second half with no first half in this packet reuses the stale one
    push_word(MsgPhase, 1'b1, 13'd100, 5'd5, 5'd0, 24'h012345);
    push_word(MsgPhase, 1'b1, 13'd100, 5'd5, 5'd2, 24'h000000);
    push_word(MsgPhase, 1'b1, 13'd100, 5'd5, 5'd3, 24'h3F1F00);
    push_word(MsgPhase, 1'b1, 13'd100, 5'd5, 5'd4, 24'hFFFFFF);

    // Random packets with some noise; hold off at the start and around the middle until all records drained
    drain_next = 1'b1;
    while (word_queue.size() < 25 + RandomWords) begin
      if (word_queue.size() > 25 + RandomWords / 2 && word_queue.size() < 40 + RandomWords / 2)
        drain_next = 1'b1;
      if ($urandom_range(0, 99) < 15) begin
        mt = $urandom_range(0, 1) ? 6'($urandom) : 6'(20 + $urandom_range(0, 1));
        push_word(mt, $urandom_range(0, 3) != 0, 13'($urandom), 5'($urandom),
                  5'($urandom), 24'($urandom));
      end else begin
        mt = $urandom_range(0, 1) ? MsgRange : MsgPhase;
        total = ($urandom_range(0, 4) == 0) ? 5'(2 * $urandom_range(2, 15) + 1)
                                              : 5'(2 * $urandom_range(2, 4) + 1);
        if ($urandom_range(0, 1)) zc = 13'($urandom);
        if ($urandom_range(0, 1)) us = 20'($urandom);
        hdr = {1'($urandom), 1'($urandom_range(0, 11) == 0), 2'($urandom), us};
        cut = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, total - 1)) : total;
        push_word(mt, 1'b1, zc, total, 5'd0, hdr);
        for (wn = 1; wn < cut; wn++) begin
          if (wn % 2 == 1) begin
            // first half: few satellites and lock values so slips and repeats occur
            a = 24'($urandom);
            a[23] = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 3) != 0) a[20:16] = 5'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 7) a[12:8] = 5'($urandom_range(0, 2));
            push_word(mt, 1'b1, zc, total, 5'(wn), a);
          end else begin
            push_word(mt, 1'b1, zc, total, 5'(wn), 24'($urandom));
          end
        end
        if ($urandom_range(0, 19) == 0) begin
          push_word(mt, 1'b1, zc, total, 5'($urandom_range(total, 31)), 24'($urandom));
        end
      end
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (word_queue.size() != 0 || word_pending) @(posedge clk_i);
    while (record_queue.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && record_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== rtcm2_hires_correction_decoder_core.f =====
rtl/rhcd_pkg.sv
rtl/rhcd_lock_mem.sv
rtl/rhcd_word_stage.sv
rtl/rtcm2_hires_correction_decoder_core.sv
bench/rtcm2_hires_correction_decoder_core_tb.sv
